// ===== sv/ptbl_pkg.sv =====
// Package for the polar table lookup: field widths, codes, row and line-unit types.
// No dependencies; every other file of the block but ptbl_ram imports it.
`default_nettype none
package ptbl_pkg;

  localparam int DEPTH_DEF = 256;

  localparam int REW = 24;
  localparam int ANW = 16;
  localparam int CFW = 16;
  localparam int CIW = 8;
  localparam int CDW = 24;

  // Internal widths of the interpolation datapath.
  localparam int CW  = 36;
  localparam int XW  = 26;
  localparam int AMW = CW + 1;
  localparam int BMW = XW + 1;
  localparam int PW  = AMW + BMW;
  localparam int DMW = XW;
  localparam int RW  = PW + 2;
  localparam int NSTEP = 6;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [2:0] ST_EXACT    = 3'd0;
  localparam logic [2:0] ST_ANGLE    = 3'd1;
  localparam logic [2:0] ST_REYNOLDS = 3'd2;
  localparam logic [2:0] ST_BILINEAR = 3'd3;
  localparam logic [2:0] ST_DEFAULT  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_ZERO_DIV = 3'd6;

  localparam logic [CIW-1:0] REG_RE_TOL   = CIW'(0);
  localparam logic [CIW-1:0] REG_ANG_TOL  = CIW'(1);
  localparam logic [CIW-1:0] REG_LIFT_DEF = CIW'(2);
  localparam logic [CIW-1:0] REG_DRAG_DEF = CIW'(3);

  typedef struct packed {
    logic [REW-1:0]        reynolds;
    logic signed [ANW-1:0] angle;
    logic signed [CFW-1:0] lift;
    logic signed [CFW-1:0] drag;
  } ptbl_row_t;

  typedef struct packed {
    logic signed [CW-1:0] y0;
    logic signed [CW-1:0] y1;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] d;
  } ptbl_line_op_t;

  typedef struct packed {
    logic                 done;
    logic signed [RW-1:0] value;
  } ptbl_line_res_t;

  function automatic logic signed [CFW-1:0] sat16(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] hi;
    logic signed [RW-1:0] lo;
    hi = RW'(32767);
    lo = -RW'(32768);
    if (v > hi) return 16'sh7fff;
    else if (v < lo) return 16'sh8000;
    else return v[CFW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/ptbl_in_if.sv =====
// Command channel interface of the polar table lookup.
// Depends on ptbl_pkg for field widths.
`default_nettype none
interface ptbl_in_if import ptbl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            command;
  logic [REW-1:0]        reynolds;
  logic signed [ANW-1:0] angle;
  logic signed [CFW-1:0] lift_coef;
  logic signed [CFW-1:0] drag_coef;
  modport source(output valid, command, reynolds, angle, lift_coef, drag_coef, input ready);
  modport sink(input valid, command, reynolds, angle, lift_coef, drag_coef, output ready);
endinterface
`default_nettype wire

// ===== sv/ptbl_out_if.sv =====
// Result channel interface of the polar table lookup.
// Depends on ptbl_pkg for field widths.
`default_nettype none
interface ptbl_out_if import ptbl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [CFW-1:0] lift_result;
  logic signed [CFW-1:0] drag_result;
  logic [2:0]            match_count;
  logic [2:0]            status;
  modport source(output valid, lift_result, drag_result, match_count, status, input ready);
  modport sink(input valid, lift_result, drag_result, match_count, status, output ready);
endinterface
`default_nettype wire

// ===== sv/ptbl_cfg_if.sv =====
// Register write channel interface of the polar table lookup.
// Depends on ptbl_pkg for index and data widths.
`default_nettype none
interface ptbl_cfg_if import ptbl_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [CIW-1:0] index;
  logic [CDW-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/ptbl_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none
module ptbl_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== sv/ptbl_line.sv =====
// Iterative linear step y0 + ((y1 - y0) * (x - x0)) / d, quotient truncated toward zero.
// Shift-add multiply, then restoring division; depends on ptbl_pkg.
`default_nettype none
module ptbl_line import ptbl_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire ptbl_line_op_t  op,
  output      ptbl_line_res_t res
);
  localparam int CTW = $clog2(PW);
  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_MUL  = 2'd1;
  localparam logic [1:0] L_DIV  = 2'd2;
  localparam logic [1:0] L_FIN  = 2'd3;

  logic [1:0]           st_r;
  logic [CTW-1:0]       cnt_r;
  logic signed [CW-1:0] y0_r;
  logic                 neg_r;
  logic [PW-1:0]        mc_r;
  logic [BMW-1:0]       mp_r;
  logic [PW-1:0]        acc_r;
  logic [DMW-1:0]       dm_r;
  logic [DMW-1:0]       rem_r;
  logic                 done_r;
  logic signed [RW-1:0] value_r;

  logic signed [CW:0]   a_w;
  logic signed [XW:0]   b_w;
  logic [CW:0]          am_w;
  logic [XW:0]          bm_w;
  logic [DMW-1:0]       dm_w;
  logic [DMW:0]         trial_w;
  logic                 ge_w;
  logic signed [RW-1:0] q_w;

  always_comb begin
    a_w  = {op.y1[CW-1], op.y1} - {op.y0[CW-1], op.y0};
    b_w  = {op.x[XW-1], op.x} - {op.x0[XW-1], op.x0};
    am_w = a_w[CW] ? -a_w : a_w;
    bm_w = b_w[XW] ? -b_w : b_w;
    dm_w = op.d[XW-1] ? -op.d : op.d;
    trial_w = {rem_r, acc_r[PW-1]};
    ge_w    = trial_w >= {1'b0, dm_r};
    q_w     = $signed({2'b00, acc_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= (st_r == L_FIN);
      unique case (st_r)
        L_IDLE: begin
          if (start) begin
            y0_r  <= op.y0;
            neg_r <= a_w[CW] ^ b_w[XW] ^ op.d[XW-1];
            mc_r  <= PW'(am_w);
            mp_r  <= bm_w;
            dm_r  <= dm_w;
            acc_r <= '0;
            rem_r <= '0;
            cnt_r <= '0;
            st_r  <= L_MUL;
          end
        end
        L_MUL: begin
          if (mp_r[0]) begin
            acc_r <= acc_r + mc_r;
          end
          mc_r <= {mc_r[PW-2:0], 1'b0};
          mp_r <= {1'b0, mp_r[BMW-1:1]};
          if (cnt_r == CTW'(BMW - 1)) begin
            cnt_r <= '0;
            st_r  <= L_DIV;
          end else begin
            cnt_r <= cnt_r + CTW'(1);
          end
        end
        L_DIV: begin
          rem_r <= ge_w ? DMW'(trial_w - {1'b0, dm_r}) : trial_w[DMW-1:0];
          acc_r <= {acc_r[PW-2:0], ge_w};
          if (cnt_r == CTW'(PW - 1)) begin
            st_r <= L_FIN;
          end else begin
            cnt_r <= cnt_r + CTW'(1);
          end
        end
        L_FIN: begin
          value_r <= {{(RW-CW){y0_r[CW-1]}}, y0_r} + (neg_r ? -q_w : q_w);
          st_r    <= L_IDLE;
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  assign res.done  = done_r;
  assign res.value = value_r;
endmodule
`default_nettype wire

// ===== sv/polar_table_bilinear_lookup.sv =====
// Top level of the polar table lookup: command decode, table scan and step sequencer.
// Depends on ptbl_pkg, the three channel interfaces, ptbl_ram and ptbl_line.
//
//   channel  dir  beat carries
//   in_ch    in   command, reynolds, angle, lift_coef, drag_coef
//   out_ch   out  lift_result, drag_result, match_count, status
//   cfg_ch   in   index, data (always ready)
//
// Clear and append go from idle straight to the put state. A query scans the stored points,
// one table read a cycle (an empty table skips the scan), then runs each interpolation
// step on the shared multiply-divide unit: two steps for a pair, six for a bilinear fit.
// Reset is synchronous and empties the table; the store itself is not cleared.
// A result waits in the output register while the next command is accepted.
`default_nettype none
module polar_table_bilinear_lookup import ptbl_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  ptbl_in_if.sink    in_ch,
  ptbl_out_if.source out_ch,
  ptbl_cfg_if.sink   cfg_ch
);
  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int SW   = $clog2(NSTEP);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_GO     = 3'd4;
  localparam logic [2:0] S_WAIT   = 3'd5;
  localparam logic [2:0] S_FINAL  = 3'd6;
  localparam logic [2:0] S_PUT    = 3'd7;

  localparam logic [1:0] MODE_ANGLE = 2'd0;
  localparam logic [1:0] MODE_REYN  = 2'd1;
  localparam logic [1:0] MODE_BILIN = 2'd2;

  logic [2:0]            state_r;
  logic [CNTW-1:0]       cnt_r;
  logic [AW-1:0]         scan_r;
  logic                  vld_r;
  logic [2:0]            mcnt_r;
  ptbl_row_t             mrow_r [4];
  logic [REW-1:0]        q_re_r;
  logic signed [ANW-1:0] q_ang_r;
  logic [1:0]            mode_r;
  logic [SW-1:0]         step_r;
  logic [SW-1:0]         last_r;
  logic signed [RW-1:0]  res_r [NSTEP];

  logic [REW-1:0]        re_tol_r;
  logic [ANW-2:0]        ang_tol_r;
  logic signed [CFW-1:0] lift_def_r;
  logic signed [CFW-1:0] drag_def_r;

  logic signed [CFW-1:0] pl_r;
  logic signed [CFW-1:0] pd_r;
  logic [2:0]            pc_r;
  logic [2:0]            ps_r;

  logic                  out_valid_r;
  logic signed [CFW-1:0] out_lift_r;
  logic signed [CFW-1:0] out_drag_r;
  logic [2:0]            out_cnt_r;
  logic [2:0]            out_st_r;

  logic           accept_w;
  logic           full_w;
  logic           ram_we_w;
  ptbl_row_t      wrow_w;
  ptbl_row_t      rrow_w;
  logic [REW:0]   dre_w;
  logic [REW:0]   are_w;
  logic [ANW:0]   dang_w;
  logic [ANW:0]   aang_w;
  logic           near_w;
  logic           start_w;
  ptbl_line_op_t  op_w;
  ptbl_line_res_t lres_w;
  logic signed [XW-1:0] xang_w;
  logic signed [XW-1:0] xre_w;
  logic signed [XW-1:0] a0_w, a1_w, a2_w, a3_w, r0_w, r1_w, r2_w;

  assign accept_w = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign full_w = !(cnt_r < CNTW'(TABLE_DEPTH));
  assign ram_we_w = accept_w && (in_ch.command == CMD_APPEND) && !full_w;
  assign start_w = (state_r == S_GO);

  always_comb begin
    wrow_w.reynolds = in_ch.reynolds;
    wrow_w.angle    = in_ch.angle;
    wrow_w.lift     = in_ch.lift_coef;
    wrow_w.drag     = in_ch.drag_coef;
  end

  ptbl_ram #(.W($bits(ptbl_row_t)), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we_w),
    .waddr(cnt_r[AW-1:0]),
    .wdata(wrow_w),
    .re   (state_r == S_SCAN),
    .raddr(scan_r),
    .rdata(rrow_w)
  );

  always_comb begin
    dre_w  = {1'b0, q_re_r} - {1'b0, rrow_w.reynolds};
    are_w  = dre_w[REW] ? -dre_w : dre_w;
    dang_w = {q_ang_r[ANW-1], q_ang_r} - {rrow_w.angle[ANW-1], rrow_w.angle};
    aang_w = dang_w[ANW] ? -dang_w : dang_w;
    near_w = (are_w < {1'b0, re_tol_r}) && (aang_w < {2'b00, ang_tol_r});
  end

  always_comb begin
    xang_w = XW'(q_ang_r);
    xre_w  = $signed(XW'(q_re_r));
    a0_w = XW'(mrow_r[0].angle);
    a1_w = XW'(mrow_r[1].angle);
    a2_w = XW'(mrow_r[2].angle);
    a3_w = XW'(mrow_r[3].angle);
    r0_w = $signed(XW'(mrow_r[0].reynolds));
    r1_w = $signed(XW'(mrow_r[1].reynolds));
    r2_w = $signed(XW'(mrow_r[2].reynolds));
    op_w.y0 = CW'(mrow_r[0].lift);
    op_w.y1 = CW'(mrow_r[1].lift);
    op_w.x  = xang_w;
    op_w.x0 = a0_w;
    op_w.d  = a1_w - a0_w;
    unique case (mode_r)
      MODE_REYN: begin
        op_w.x  = xre_w;
        op_w.x0 = r0_w;
        op_w.d  = r1_w - r0_w;
        if (step_r[0]) begin
          op_w.y0 = CW'(mrow_r[0].drag);
          op_w.y1 = CW'(mrow_r[1].drag);
        end
      end
      MODE_BILIN: begin
        unique case (step_r)
          SW'(1): begin
            op_w.y0 = CW'(mrow_r[2].lift);
            op_w.y1 = CW'(mrow_r[3].lift);
            op_w.x0 = a2_w;
            op_w.d  = a3_w - a2_w;
          end
          SW'(2): begin
            op_w.y0 = CW'(mrow_r[0].drag);
            op_w.y1 = CW'(mrow_r[1].drag);
          end
          SW'(3): begin
            op_w.y0 = CW'(mrow_r[2].drag);
            op_w.y1 = CW'(mrow_r[3].drag);
            op_w.x0 = a2_w;
            op_w.d  = a3_w - a2_w;
          end
          SW'(4): begin
            op_w.y0 = res_r[0][CW-1:0];
            op_w.y1 = res_r[1][CW-1:0];
            op_w.x  = xre_w;
            op_w.x0 = r0_w;
            op_w.d  = r2_w - r0_w;
          end
          SW'(5): begin
            op_w.y0 = res_r[2][CW-1:0];
            op_w.y1 = res_r[3][CW-1:0];
            op_w.x  = xre_w;
            op_w.x0 = r0_w;
            op_w.d  = r2_w - r0_w;
          end
          default: begin
          end
        endcase
      end
      default: begin
        if (step_r[0]) begin
          op_w.y0 = CW'(mrow_r[0].drag);
          op_w.y1 = CW'(mrow_r[1].drag);
        end
      end
    endcase
  end

  ptbl_line u_line (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start_w),
    .op   (op_w),
    .res  (lres_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      re_tol_r   <= REW'(50000);
      ang_tol_r  <= (ANW-1)'(64);
      lift_def_r <= '0;
      drag_def_r <= CFW'(4096);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_RE_TOL:   re_tol_r   <= cfg_ch.data[REW-1:0];
        REG_ANG_TOL:  ang_tol_r  <= cfg_ch.data[ANW-2:0];
        REG_LIFT_DEF: lift_def_r <= cfg_ch.data[CFW-1:0];
        REG_DRAG_DEF: drag_def_r <= cfg_ch.data[CFW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (vld_r && near_w) begin
      if (mcnt_r < 3'd4) begin
        mrow_r[mcnt_r[1:0]] <= rrow_w;
      end
    end
    if (state_r == S_WAIT && lres_w.done) begin
      res_r[step_r] <= lres_w.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      vld_r       <= 1'b0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r <= (state_r == S_SCAN);
      if (vld_r && near_w && mcnt_r < 3'd5) begin
        mcnt_r <= mcnt_r + 3'd1;
      end
      if (out_valid_r && out_ch.ready && state_r != S_PUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept_w) begin
            pl_r   <= '0;
            pd_r   <= '0;
            pc_r   <= '0;
            mcnt_r <= '0;
            q_re_r  <= in_ch.reynolds;
            q_ang_r <= in_ch.angle;
            scan_r  <= '0;
            ps_r <= (in_ch.command == CMD_APPEND && full_w) ? ST_FULL : ST_EXACT;
            if (in_ch.command == CMD_QUERY) begin
              state_r <= (cnt_r == '0) ? S_DECIDE : S_SCAN;
            end else begin
              state_r <= S_PUT;
            end
            if (in_ch.command == CMD_CLEAR) begin
              cnt_r <= '0;
            end else if (in_ch.command == CMD_APPEND && !full_w) begin
              cnt_r <= cnt_r + CNTW'(1);
            end
          end
        end
        S_SCAN: begin
          if (CNTW'(scan_r) == cnt_r - CNTW'(1)) begin
            state_r <= S_DRAIN;
          end else begin
            scan_r <= scan_r + AW'(1);
          end
        end
        S_DRAIN: begin
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          pc_r   <= mcnt_r;
          step_r <= '0;
          if (mcnt_r == 3'd1 || mcnt_r == 3'd2 || mcnt_r == 3'd4) begin
            pl_r <= mrow_r[0].lift;
            pd_r <= mrow_r[0].drag;
          end else begin
            pl_r <= lift_def_r;
            pd_r <= drag_def_r;
          end
          if (mcnt_r == 3'd1) begin
            ps_r    <= ST_EXACT;
            state_r <= S_PUT;
          end else if (mcnt_r == 3'd2) begin
            if (mrow_r[0].reynolds != mrow_r[1].reynolds) begin
              mode_r  <= MODE_REYN;
              last_r  <= SW'(1);
              ps_r    <= ST_REYNOLDS;
              state_r <= S_GO;
            end else if (mrow_r[0].angle == mrow_r[1].angle) begin
              ps_r    <= ST_ZERO_DIV;
              state_r <= S_PUT;
            end else begin
              mode_r  <= MODE_ANGLE;
              last_r  <= SW'(1);
              ps_r    <= ST_ANGLE;
              state_r <= S_GO;
            end
          end else if (mcnt_r == 3'd4) begin
            if (mrow_r[0].angle == mrow_r[1].angle || mrow_r[2].angle == mrow_r[3].angle ||
                mrow_r[0].reynolds == mrow_r[2].reynolds) begin
              ps_r    <= ST_ZERO_DIV;
              state_r <= S_PUT;
            end else begin
              mode_r  <= MODE_BILIN;
              last_r  <= SW'(NSTEP - 1);
              ps_r    <= ST_BILINEAR;
              state_r <= S_GO;
            end
          end else begin
            ps_r    <= ST_DEFAULT;
            state_r <= S_PUT;
          end
        end
        S_GO: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (lres_w.done) begin
            if (step_r == last_r) begin
              state_r <= S_FINAL;
            end else begin
              step_r  <= step_r + SW'(1);
              state_r <= S_GO;
            end
          end
        end
        S_FINAL: begin
          if (mode_r == MODE_BILIN) begin
            pl_r <= sat16(res_r[4]);
            pd_r <= sat16(res_r[5]);
          end else begin
            pl_r <= sat16(res_r[0]);
            pd_r <= sat16(res_r[1]);
          end
          state_r <= S_PUT;
        end
        S_PUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_lift_r  <= pl_r;
            out_drag_r  <= pd_r;
            out_cnt_r   <= pc_r;
            out_st_r    <= ps_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.lift_result = out_lift_r;
  assign out_ch.drag_result = out_drag_r;
  assign out_ch.match_count = out_cnt_r;
  assign out_ch.status      = out_st_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_start_only_decided: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GO) |-> (mcnt_r == 3'd2 || mcnt_r == 3'd4))
    else $error("interpolation started with an unusable match count");

  a_full_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r == ST_FULL) |-> (out_cnt_r == 3'd0))
    else $error("table full result carries matches");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    lres_w.done |-> (state_r == S_WAIT))
    else $error("line unit finished outside of the wait state");
endmodule
`default_nettype wire

// ===== dv/ptbl_lookup_checker.sv =====
// Checker for the polar table lookup: watches the command, register and result channels,
// keeps its own copy of the table and the registers, and compares every result beat.
// Depends on ptbl_pkg and the three channel interfaces.
`default_nettype none
module ptbl_lookup_checker import ptbl_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  ptbl_in_if       in_ch,
  ptbl_out_if      out_ch,
  ptbl_cfg_if      cfg_ch,
  output int       error_count,
  output int       pending
);

  typedef struct {
    logic signed [CFW-1:0] lift;
    logic signed [CFW-1:0] drag;
    logic [2:0]            count;
    logic [2:0]            status;
  } coef_result_t;

  localparam int ROWS = DEPTH_DEF;

  longint       row_re[ROWS];
  longint       row_an[ROWS];
  longint       row_lift[ROWS];
  longint       row_drag[ROWS];
  int           row_count;
  longint       tol_re;
  longint       tol_an;
  longint       lift_dflt;
  longint       drag_dflt;
  coef_result_t coef_queue[$];

  function automatic longint lerp(longint y0, longint y1, longint x, longint x0, longint d);
    return y0 + ((y1 - y0) * (x - x0)) / d;
  endfunction

  function automatic logic signed [CFW-1:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return CFW'(v);
  endfunction

  function automatic coef_result_t lookup_coefs(logic [1:0] cmd, logic [REW-1:0] re_in,
                                                logic signed [ANW-1:0] an_in,
                                                logic signed [CFW-1:0] lift_in,
                                                logic signed [CFW-1:0] drag_in);
    coef_result_t r;
    longint re, an, lift, drag, dre, dan;
    longint l1, l2, d1, d2;
    int m[4];
    int n;
    re = longint'(re_in);
    an = longint'(an_in);
    lift = 0;
    drag = 0;
    n = 0;
    m = '{0, 0, 0, 0};
    r.status = ST_EXACT;
    case (cmd)
      CMD_CLEAR: begin
        row_count = 0;
      end
      CMD_APPEND: begin
        if (row_count < ROWS) begin
          row_re[row_count] = re;
          row_an[row_count] = an;
          row_lift[row_count] = longint'(lift_in);
          row_drag[row_count] = longint'(drag_in);
          row_count++;
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_QUERY: begin
        for (int i = 0; i < row_count; i++) begin
          dre = re - row_re[i];
          dan = an - row_an[i];
          if (dre < 0) dre = -dre;
          if (dan < 0) dan = -dan;
          if (dre < tol_re && dan < tol_an) begin
            if (n < 4) m[n] = i;
            if (n < 5) n++;
          end
        end
        if (n == 1 || n == 2 || n == 4) begin
          lift = row_lift[m[0]];
          drag = row_drag[m[0]];
          if (n == 2) begin
            if (row_re[m[0]] == row_re[m[1]]) begin
              if (row_an[m[0]] == row_an[m[1]]) begin
                r.status = ST_ZERO_DIV;
              end else begin
                lift = lerp(lift, row_lift[m[1]], an, row_an[m[0]],
                            row_an[m[1]] - row_an[m[0]]);
                drag = lerp(drag, row_drag[m[1]], an, row_an[m[0]],
                            row_an[m[1]] - row_an[m[0]]);
                r.status = ST_ANGLE;
              end
            end else begin
              lift = lerp(lift, row_lift[m[1]], re, row_re[m[0]], row_re[m[1]] - row_re[m[0]]);
              drag = lerp(drag, row_drag[m[1]], re, row_re[m[0]], row_re[m[1]] - row_re[m[0]]);
              r.status = ST_REYNOLDS;
            end
          end else if (n == 4) begin
            if (row_an[m[1]] == row_an[m[0]] || row_an[m[3]] == row_an[m[2]] ||
                row_re[m[2]] == row_re[m[0]]) begin
              r.status = ST_ZERO_DIV;
            end else begin
              l1 = lerp(lift, row_lift[m[1]], an, row_an[m[0]], row_an[m[1]] - row_an[m[0]]);
              d1 = lerp(drag, row_drag[m[1]], an, row_an[m[0]], row_an[m[1]] - row_an[m[0]]);
              l2 = lerp(row_lift[m[2]], row_lift[m[3]], an, row_an[m[2]],
                        row_an[m[3]] - row_an[m[2]]);
              d2 = lerp(row_drag[m[2]], row_drag[m[3]], an, row_an[m[2]],
                        row_an[m[3]] - row_an[m[2]]);
              lift = lerp(l1, l2, re, row_re[m[0]], row_re[m[2]] - row_re[m[0]]);
              drag = lerp(d1, d2, re, row_re[m[0]], row_re[m[2]] - row_re[m[0]]);
              r.status = ST_BILINEAR;
            end
          end
        end else begin
          lift = lift_dflt;
          drag = drag_dflt;
          r.status = ST_DEFAULT;
        end
      end
      default: begin
      end
    endcase
    r.lift = clip16(lift);
    r.drag = clip16(drag);
    r.count = 3'(n);
    return r;
  endfunction

  always @(posedge clk) begin
    coef_result_t got;
    coef_result_t want;
    if (!rst_n) begin
      row_count = 0;
      tol_re = 50000;
      tol_an = 64;
      lift_dflt = 0;
      drag_dflt = 4096;
      error_count = 0;
      coef_queue.delete();
      pending <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_RE_TOL:   tol_re = longint'(cfg_ch.data[REW-1:0]);
          REG_ANG_TOL:  tol_an = longint'(cfg_ch.data[14:0]);
          REG_LIFT_DEF: lift_dflt = longint'($signed(cfg_ch.data[CFW-1:0]));
          REG_DRAG_DEF: drag_dflt = longint'($signed(cfg_ch.data[CFW-1:0]));
          default: begin
          end
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got.lift = out_ch.lift_result;
        got.drag = out_ch.drag_result;
        got.count = out_ch.match_count;
        got.status = out_ch.status;
        if (coef_queue.size() == 0) begin
          $error("result beat with no expected result");
          error_count++;
        end else begin
          want = coef_queue.pop_front();
          if (got.lift !== want.lift) begin
            $error("lift_result expected %0d actual %0d", want.lift, got.lift);
            error_count++;
          end
          if (got.drag !== want.drag) begin
            $error("drag_result expected %0d actual %0d", want.drag, got.drag);
            error_count++;
          end
          if (got.count !== want.count) begin
            $error("match_count expected %0d actual %0d", want.count, got.count);
            error_count++;
          end
          if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            error_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = lookup_coefs(in_ch.command, in_ch.reynolds, in_ch.angle,
                            in_ch.lift_coef, in_ch.drag_coef);
        coef_queue = {coef_queue, want};
      end
      pending <= coef_queue.size();
    end
  end

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Top of the polar table lookup testbench: clock, reset, command and register stimulus,
// random idling on both channels, watchdog and verdict.
// Depends on ptbl_pkg, the channel interfaces, the block and ptbl_lookup_checker.
`default_nettype none
module tb_top import ptbl_pkg::*;;

  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_ITEMS = 90;

  logic clk;
  logic rst_n;
  int   sender_idle;
  int   recv_stall;
  int   tol_re;
  int   tol_an;
  int   error_count;
  int   pending;
  int   quiet_cycles;
  int   sent;

  ptbl_in_if  in_ch();
  ptbl_out_if out_ch();
  ptbl_cfg_if cfg_ch();

  polar_table_bilinear_lookup dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  ptbl_lookup_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .error_count(error_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic send_cmd(input logic [1:0] cmd, input int re, input int an,
                          input int lc, input int dc);
    while ($urandom_range(99) < sender_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.reynolds <= REW'(re);
    in_ch.angle <= ANW'(an);
    in_ch.lift_coef <= CFW'(lc);
    in_ch.drag_coef <= CFW'(dc);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic append_row(input int re, input int an, input int lc, input int dc);
    send_cmd(CMD_APPEND, re, an, lc, dc);
  endtask

  task automatic query_at(input int re, input int an);
    send_cmd(CMD_QUERY, re, an, $urandom, $urandom);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_regs(input int re_tol, input int an_tol, input int ld, input int dd);
    int vals[4];
    vals = '{re_tol, an_tol, ld, dd};
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= CIW'(i);
      cfg_ch.data <= CDW'(vals[i]);
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
    tol_re = re_tol;
    tol_an = an_tol;
  endtask

  task automatic polar_burst();
    int dr, da, r0, a0, kind, nq;
    dr = $urandom_range(0, (tol_re - 1 < 4000000) ? tol_re - 1 : 4000000);
    da = $urandom_range(0, (tol_an - 1 < 3000) ? tol_an - 1 : 3000);
    if ($urandom_range(9) == 0) dr = 0;
    if ($urandom_range(9) == 0) da = 0;
    r0 = $urandom_range(0, 16777215 - dr);
    a0 = int'($urandom_range(0, 65535 - da)) - 32768;
    kind = $urandom_range(0, 3);
    send_cmd(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
    append_row(r0, a0, $urandom, $urandom);
    if (kind == 1) append_row(r0, a0 + da, $urandom, $urandom);
    if (kind == 2) append_row(r0 + dr, a0 + $urandom_range(0, da), $urandom, $urandom);
    if (kind == 3) begin
      append_row(r0, a0 + da, $urandom, $urandom);
      append_row(r0 + dr, a0, $urandom, $urandom);
      append_row(r0 + dr, a0 + da, $urandom, $urandom);
    end
    nq = $urandom_range(1, 3);
    for (int i = 0; i < nq; i++) begin
      query_at(r0 + $urandom_range(0, dr), a0 + $urandom_range(0, da));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_CLEAR;
    in_ch.reynolds = '0;
    in_ch.angle = '0;
    in_ch.lift_coef = '0;
    in_ch.drag_coef = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_RE_TOL;
    cfg_ch.data = '0;
    sender_idle = 0;
    recv_stall = 0;
    tol_re = 50000;
    tol_an = 64;
    quiet_cycles = 0;
    sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    query_at(0, 0);
    append_row(0, -32768, 32767, -32768);
    query_at(0, -32768);
    append_row(16777215, 32767, -32768, 32767);
    query_at(16777215, 32767);
    send_cmd(2'd3, 16777215, -1, -1, -1);
    send_cmd(CMD_CLEAR, 0, 0, 0, 0);
    append_row(1000, 0, -32768, 100);
    append_row(1000, 1, 32767, 200);
    query_at(1000, 40);
    append_row(1000, 1, 5, 5);
    query_at(1000, 0);
    append_row(1000, 2, 7, 7);
    query_at(1000, 1);
    append_row(1001, 3, 9, 9);
    query_at(1000, 1);
    send_cmd(CMD_CLEAR, 0, 0, 0, 0);
    append_row(100000, 100, 4096, -4096);
    append_row(130000, 100, -4096, 4096);
    query_at(115000, 100);
    append_row(100000, 100, 1, 1);
    append_row(130000, 140, 2, 2);
    query_at(110000, 120);
    send_cmd(CMD_CLEAR, 0, 0, 0, 0);
    append_row(5000, 7, 11, 12);
    append_row(5000, 7, 13, 14);
    query_at(5000, 7);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        1: write_regs(16777215, 32767, -32768, 32767);
        2: write_regs(1, 1, 32767, -32768);
        3: write_regs(300000, 2000, $urandom, $urandom);
        4: write_regs(50000, 64, 0, 4096);
        default: begin
        end
      endcase
      case (ph % 4)
        0: begin sender_idle = 0; recv_stall = 0; end
        1: begin sender_idle = 49; recv_stall = 0; end
        2: begin sender_idle = 0; recv_stall = 49; end
        default: begin sender_idle = 37; recv_stall = 37; end
      endcase
      if (ph == 3) begin
        send_cmd(CMD_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < DEPTH_DEF + 1; i++) append_row($urandom, $urandom, $urandom, $urandom);
        query_at($urandom, $urandom);
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(99) < 70) begin
          polar_burst();
        end else begin
          send_cmd(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
